// ----- hdl/fcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants of the fan curve speed selector.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int CURVE_DEPTH_DEF  = 64;
  localparam int WINDOW_DEPTH_DEF = 10;

  // running total width and shared unit width
  localparam int TOT_W = 11;
  localparam int UNIT_W = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_DELAY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_LENGTH = 3'd5;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] temperature;
    logic [5:0] entry_index;
    logic [6:0] entry_speed;
  } in_item_t;

  typedef struct packed {
    logic [6:0] fan_speed;
    logic [1:0] wait_seconds;
    logic       forced_max;
  } out_item_t;

  typedef struct packed {
    logic              sub;
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] res;
    logic              borrow;
  } alu_rsp_t;

endpackage

// ----- hdl/fcs_alu.sv -----
// ----------------------------------------------------------------------------
// fcs_alu
// Shared add / subtract unit with borrow flag.
// ----------------------------------------------------------------------------
module fcs_alu (
  input  fcs_pkg::alu_req_t req,
  output fcs_pkg::alu_rsp_t rsp
);
  import fcs_pkg::*;

  logic [UNIT_W:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b ^ {UNIT_W{req.sub}}}
             + {{UNIT_W{1'b0}}, req.sub};
  assign rsp.res    = sum[UNIT_W-1:0];
  assign rsp.borrow = req.sub & ~sum[UNIT_W];

endmodule

// ----- hdl/fan_curve_speed_selector_unit.sv -----
// ----------------------------------------------------------------------------
// fan_curve_speed_selector_unit
// Moving-average temperature to fan speed lookup through a loaded curve.
// ----------------------------------------------------------------------------
// Load and clear requests are handled in idle. A temperature sample runs
// through the drop, add, divide, offset, length, read and output states
// before its result is offered. The divide is an 11-step restoring divide of
// the running total by the sample count, all done on one shared add/subtract
// unit together with the total update and the index compares. The input is
// stalled while a sample is in work; a finished result waits in the output
// register, and a sample whose result finds that register still held waits
// in its last step. Curve table and sample ring are not cleared at reset, so
// there is no clearing pass.
module fan_curve_speed_selector_unit #(
  parameter int CURVE_DEPTH  = fcs_pkg::CURVE_DEPTH_DEF,
  parameter int WINDOW_DEPTH = fcs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fcs_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fcs_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fcs_pkg::*;

  localparam int TW  = $clog2(CURVE_DEPTH);
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int HW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int BCW = $clog2(TOT_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DROP = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OFF  = 3'd4;
  localparam logic [2:0] S_LEN  = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [3:0] win_cnt_r;
  logic [6:0] offset_r, high_r, low_r, length_r;
  logic [1:0] delay_r;

  logic [2:0]        state_r, state_nxt;
  logic [HW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W-1:0]  div_r, div_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BCW-1:0]    bit_r, bit_nxt;
  logic [UNIT_W-1:0] idx_r, idx_nxt;
  logic [6:0]        temp_r, temp_nxt;
  logic              drop_r, drop_nxt;
  logic              forced_r, forced_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [6:0] ring_mem [WINDOW_DEPTH];
  logic [6:0] ring_rd_r;
  logic [6:0] tbl_mem [CURVE_DEPTH];
  logic [6:0] tbl_rd_r;

  alu_req_t req;
  alu_rsp_t rsp;

  logic              in_acc;
  logic [3:0]        win_raw;
  logic [CW-1:0]     win_e;
  logic [6:0]        hi_e, off_e;
  logic [1:0]        dly_e;
  logic [UNIT_W-1:0] len_e, lenm1;
  logic [HW-1:0]     oldest;
  logic [CW:0]       old_sum;
  logic              drop_now;
  logic              tbl_we;
  logic [6:0]        spd_clamp;
  logic [CW:0]       trial;
  logic              out_load;

  fcs_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // effective configuration
  always_comb begin
    win_raw = (win_cnt_r > 4'd10) ? 4'd7 : ((win_cnt_r == 4'd0) ? 4'd1 : win_cnt_r);
    win_e   = (int'(win_raw) > WINDOW_DEPTH) ? CW'(WINDOW_DEPTH) : CW'(win_raw);
    hi_e    = (high_r > 7'd100) ? 7'd100 : high_r;
    off_e   = (offset_r > 7'd80) ? 7'd80 : offset_r;
    dly_e   = (delay_r == 2'd1 || delay_r == 2'd2) ? delay_r : 2'd2;
    if (length_r < 7'd10) begin
      len_e = UNIT_W'(10);
    end else if (int'(length_r) > CURVE_DEPTH) begin
      len_e = UNIT_W'(CURVE_DEPTH);
    end else begin
      len_e = UNIT_W'(length_r);
    end
    lenm1 = len_e - UNIT_W'(1);
  end

  always_comb begin
    if ({1'b0, head_r} >= (CW+1)'(count_r)) begin
      old_sum = (CW+1)'(head_r) - (CW+1)'(count_r);
    end else begin
      old_sum = (CW+1)'(head_r) + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(count_r);
    end
    oldest   = old_sum[HW-1:0];
    drop_now = (count_r >= win_e);
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign spd_clamp = (in_data.entry_speed > 7'd100) ? 7'd100 : in_data.entry_speed;
  assign tbl_we = in_acc && (in_data.kind == KIND_LOAD)
               && (UNIT_W'(in_data.entry_index) < UNIT_W'(CURVE_DEPTH));
  assign trial = {rem_r, div_r[TOT_W-1]};
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // shared unit operand select
  always_comb begin
    req = '0;
    unique case (state_r)
      S_DROP: begin
        req.sub = 1'b1;
        req.a   = UNIT_W'(total_r);
        req.b   = drop_r ? UNIT_W'(ring_rd_r) : '0;
      end
      S_ADD: begin
        req.sub = 1'b0;
        req.a   = UNIT_W'(total_r);
        req.b   = UNIT_W'(temp_r);
      end
      S_DIV: begin
        req.sub = 1'b1;
        req.a   = UNIT_W'(trial);
        req.b   = UNIT_W'(count_r);
      end
      S_OFF: begin
        req.sub = 1'b1;
        req.a   = UNIT_W'(div_r);
        req.b   = UNIT_W'(off_e);
      end
      S_LEN: begin
        req.sub = 1'b1;
        req.a   = lenm1;
        req.b   = idx_r;
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    temp_nxt      = temp_r;
    drop_nxt      = drop_r;
    forced_nxt    = forced_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.kind)
            KIND_SAMPLE: begin
              temp_nxt  = in_data.temperature;
              drop_nxt  = drop_now;
              state_nxt = S_DROP;
            end
            KIND_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
              total_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_DROP: begin
        total_nxt = rsp.res[TOT_W-1:0];
        if (drop_r) begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        total_nxt = rsp.res[TOT_W-1:0];
        div_nxt   = rsp.res[TOT_W-1:0];
        rem_nxt   = '0;
        bit_nxt   = '0;
        count_nxt = count_r + CW'(1);
        head_nxt  = (int'(head_r) == WINDOW_DEPTH - 1) ? '0 : head_r + HW'(1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rsp.borrow ? trial[CW-1:0] : rsp.res[CW-1:0];
        div_nxt = {div_r[TOT_W-2:0], ~rsp.borrow};
        bit_nxt = bit_r + BCW'(1);
        if (int'(bit_r) == TOT_W - 1) begin
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        idx_nxt   = rsp.borrow ? '0 : rsp.res;
        state_nxt = S_LEN;
      end
      S_LEN: begin
        forced_nxt = rsp.borrow || (temp_r >= hi_e) || (temp_r == 7'd0);
        if (forced_nxt) begin
          idx_nxt = lenm1;
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_data_nxt.fan_speed    = tbl_rd_r;
          out_data_nxt.wait_seconds = (temp_r > low_r) ? 2'd1 : dly_e;
          out_data_nxt.forced_max   = forced_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      win_cnt_r   <= 4'd7;
      offset_r    <= 7'd30;
      high_r      <= 7'd92;
      low_r       <= 7'd72;
      delay_r     <= 2'd2;
      length_r    <= 7'd60;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_COUNT: win_cnt_r <= cfg_data[3:0];
          REG_CURVE_OFFSET: offset_r  <= cfg_data;
          REG_HIGH_TEMP:    high_r    <= cfg_data;
          REG_LOW_TEMP:     low_r     <= cfg_data;
          REG_LOW_DELAY:    delay_r   <= cfg_data[1:0];
          REG_CURVE_LENGTH: length_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
    temp_r     <= temp_nxt;
    drop_r     <= drop_nxt;
    forced_r   <= forced_nxt;
    out_data_r <= out_data_nxt;
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (state_r == S_ADD) begin
      ring_mem[head_r] <= temp_r;
    end
    ring_rd_r <= ring_mem[oldest];
  end

  // curve table
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[TW'(in_data.entry_index)] <= spd_clamp;
    end
    tbl_rd_r <= tbl_mem[idx_r[TW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(count_r) <= WINDOW_DEPTH) && (int'(head_r) < WINDOW_DEPTH))
    else $error("sample window count or head out of range");

  a_index_in_curve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (idx_r <= lenm1))
    else $error("curve index past last valid entry");

  a_clear_window: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == KIND_CLEAR) |=> (count_r == '0 && total_r == '0))
    else $error("clear request left window state");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside output step");

endmodule
